// ===== hw/rtl/adsr_pkg.sv =====
// Shared constants and codes for the ADSR envelope generator.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

   // Parameter defaults
   localparam int DEF_COUNT_BITS = 24;
   localparam int DEF_LEVEL_BITS = 15;

   // Register widths
   localparam int RAMP_W     = 20;   // attack, decay and release lengths
   localparam int SUSTAIN_W  = 15;
   localparam int TOTAL_W    = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL   = 3'd4;

   // Phase codes on the result channel
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_ATTACK   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DECAY    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SUSTAIN  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RELEASE  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_FINISHED = 3'd4;
   localparam logic [PHASE_W-1:0] PH_FLAT     = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/adsr_if.sv =====
// Request and response channel interfaces of the ADSR envelope generator.
`timescale 1ns / 1ps
`default_nettype none

interface adsr_req_if;
   logic valid;
   logic ready;
   logic note_start;

   modport source (output valid, output note_start, input ready);
   modport sink   (input valid, input note_start, output ready);
endinterface

interface adsr_rsp_if
   import adsr_pkg::*;
#(
   parameter int LEVEL_BITS = DEF_LEVEL_BITS
);
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] level;
   logic [PHASE_W-1:0]    phase;

   modport source (output valid, output level, output phase, input ready);
   modport sink   (input valid, input level, input phase, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adsr_mul_div.sv =====
// Shared multiply then restoring-divide unit: quotient = (mul_a * mul_b) / divisor.
`timescale 1ns / 1ps
`default_nettype none

module adsr_mul_div
   import adsr_pkg::*;
#(
   parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [LEVEL_BITS-1:0] mul_a,
   input  wire logic [RAMP_W-1:0]     mul_b,
   input  wire logic [RAMP_W-1:0]     divisor,
   output      logic                  done,
   output      logic [LEVEL_BITS-1:0] quotient
);

   // mul_b never exceeds divisor, so the quotient fits LEVEL_BITS and
   // the upper product bits already form a partial remainder below divisor.
   localparam int PROD_W = LEVEL_BITS + RAMP_W;
   localparam int STEP_W = $clog2(LEVEL_BITS);

   logic [RAMP_W-1:0]     rem_ff, rem_in;
   logic [LEVEL_BITS-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [PROD_W-1:0]     product;
   logic [RAMP_W:0]       trial;
   logic [RAMP_W:0]       diff;
   logic                  fits;

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   // one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[LEVEL_BITS-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = product[PROD_W-1:LEVEL_BITS];
         quo_in = product[LEVEL_BITS-1:0];
         cnt_in = STEP_W'(LEVEL_BITS - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
         quo_in = {quo_ff[LEVEL_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_envelope_generator_core.sv =====
// Top level of the linear ADSR envelope generator.
`timescale 1ns / 1ps
`default_nettype none

// One request beat is one sample tick; it returns one response beat with the
// envelope level (unsigned, LEVEL_BITS fraction bits) and the phase code.
// A tick in attack, decay or release registers its operands on acceptance,
// passes the multiplier state, which starts the shared one-bit-per-cycle
// restoring divider, waits in the divide state for the divider's registered
// done flag, and forms the level as the output state loads the response
// register. Sustain, finished and the constant-level case go from acceptance
// straight to the output state, which loads the response register once it
// is free or being emptied. req ready is high only while the sequencer is
// idle, so the next tick is accepted only after the previous one has loaded
// the response register, which a response still waiting there delays. A
// finished response waits in its own register, so the next tick may be
// accepted before the previous response is taken.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module adsr_envelope_generator_core
   import adsr_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   adsr_req_if.sink                   req_bus,
   adsr_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CMP_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
   localparam logic [LEVEL_BITS-1:0] PEAK =
      LEVEL_BITS'((64'd9 << LEVEL_BITS) / 64'd10);
   localparam logic [LEVEL_BITS-1:0] FLAT =
      LEVEL_BITS'((64'd8 << LEVEL_BITS) / 64'd10);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // how the quotient turns into the level
   typedef enum logic [1:0] {
      OP_DIRECT = 2'd0,
      OP_QUO    = 2'd1,
      OP_SUB    = 2'd2,
      OP_ADD    = 2'd3
   } op_type;

   // configuration registers
   logic [RAMP_W-1:0]    attack_ff, decay_ff, release_ff;
   logic [SUSTAIN_W-1:0] sustain_ff;
   logic [TOTAL_W-1:0]   total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= '0;
         decay_ff   <= '0;
         release_ff <= '0;
         sustain_ff <= '0;
         total_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTACK:  attack_ff  <= csr_wdata[RAMP_W-1:0];
            CSR_DECAY:   decay_ff   <= csr_wdata[RAMP_W-1:0];
            CSR_RELEASE: release_ff <= csr_wdata[RAMP_W-1:0];
            CSR_SUSTAIN: sustain_ff <= csr_wdata[SUSTAIN_W-1:0];
            CSR_TOTAL:   total_ff   <= csr_wdata[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [LEVEL_BITS-1:0] mul_a_ff, mul_a_in;
   logic [RAMP_W-1:0]     mul_b_ff, mul_b_in;
   logic [RAMP_W-1:0]     div_ff, div_in;
   logic [LEVEL_BITS-1:0] direct_ff, direct_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic [PHASE_W-1:0]    rsp_phase_ff, rsp_phase_in;

   logic                  req_fire;
   logic                  div_start;
   logic                  div_done;
   logic [LEVEL_BITS-1:0] div_quo;
   logic                  out_load;

   // tick position and phase decode
   logic [COUNT_BITS-1:0] p;
   logic [CMP_W-1:0]      p_x, t_x, a_x, ad_sum, adr_sum, rel_start;
   logic [CMP_W-1:0]      k_x, left_x;
   logic [LEVEL_BITS-1:0] s_lvl;
   logic                  s_above;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign p         = req_bus.note_start ? '0 : pos_ff;
   assign p_x       = CMP_W'(p);
   assign t_x       = CMP_W'(total_ff);
   assign a_x       = CMP_W'(attack_ff);
   assign ad_sum    = a_x + CMP_W'(decay_ff);
   assign adr_sum   = ad_sum + CMP_W'(release_ff);
   assign rel_start = t_x - CMP_W'(release_ff);
   assign k_x       = p_x - a_x;
   assign left_x    = t_x - p_x;
   assign s_lvl     = LEVEL_BITS'(sustain_ff);
   assign s_above   = s_lvl > PEAK;

   always_comb begin
      op_in     = op_ff;
      phase_in  = phase_ff;
      mul_a_in  = mul_a_ff;
      mul_b_in  = mul_b_ff;
      div_in    = div_ff;
      direct_in = direct_ff;
      if (adr_sum >= t_x) begin
         op_in     = OP_DIRECT;
         phase_in  = PH_FLAT;
         direct_in = FLAT;
      end else if (p_x >= t_x) begin
         op_in     = OP_DIRECT;
         phase_in  = PH_FINISHED;
         direct_in = '0;
      end else if (p_x < a_x) begin
         op_in    = OP_QUO;
         phase_in = PH_ATTACK;
         mul_a_in = PEAK;
         mul_b_in = p_x[RAMP_W-1:0];
         div_in   = attack_ff;
      end else if (p_x < ad_sum) begin
         op_in    = s_above ? OP_ADD : OP_SUB;
         phase_in = PH_DECAY;
         mul_a_in = s_above ? (s_lvl - PEAK) : (PEAK - s_lvl);
         mul_b_in = k_x[RAMP_W-1:0];
         div_in   = decay_ff;
      end else if (p_x >= rel_start) begin
         op_in    = OP_QUO;
         phase_in = PH_RELEASE;
         mul_a_in = s_lvl;
         mul_b_in = left_x[RAMP_W-1:0];
         div_in   = release_ff;
      end else begin
         op_in     = OP_DIRECT;
         phase_in  = PH_SUSTAIN;
         direct_in = s_lvl;
      end
   end

   // position advances on every tick and saturates
   assign pos_in = (p == COUNT_MAX) ? p : p + 1'b1;

   // response register is free or being emptied
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (op_in == OP_DIRECT) ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // level from the quotient
   always_comb begin
      case (op_ff)
         OP_QUO:  rsp_level_in = div_quo;
         OP_SUB:  rsp_level_in = PEAK - div_quo;
         OP_ADD:  rsp_level_in = PEAK + div_quo;
         default: rsp_level_in = direct_ff;
      endcase
      rsp_phase_in = phase_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            pos_ff <= pos_in;
         end
      end
      if (req_fire) begin
         op_ff     <= op_in;
         phase_ff  <= phase_in;
         mul_a_ff  <= mul_a_in;
         mul_b_ff  <= mul_b_in;
         div_ff    <= div_in;
         direct_ff <= direct_in;
      end
      if (out_load) begin
         rsp_level_ff <= rsp_level_in;
         rsp_phase_ff <= rsp_phase_in;
      end
   end

   adsr_mul_div #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_mul_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mul_a    (mul_a_ff),
      .mul_b    (mul_b_ff),
      .divisor  (div_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.level = rsp_level_ff;
   assign rsp_bus.phase = rsp_phase_ff;

`ifndef SYNTH
   // a tick in flight blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request accepted while a tick is in flight");

   // divider finishes only while the sequencer waits on it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done outside the divide state");

   // a note start leaves the position at one
   a_note_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.note_start |=> pos_ff == COUNT_BITS'(1))
      else $error("position not restarted by note start");

   // a loaded response carries a defined phase code
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_phase_ff <= PH_FLAT)
      else $error("response phase code out of range");
`endif

endmodule

`default_nettype wire

// ===== sim/adsr_envelope_generator_core_tb.sv =====
// Self-checking testbench for the linear ADSR envelope generator core.
`timescale 1ns / 1ps

module adsr_envelope_generator_core_tb;
   import adsr_pkg::*;

   localparam int COUNT_BITS = DEF_COUNT_BITS;
   localparam int LEVEL_BITS = DEF_LEVEL_BITS;

   localparam longint unsigned COUNT_MAX  = (64'd1 << COUNT_BITS) - 1;
   localparam longint unsigned PEAK_LEVEL = (64'd9 << LEVEL_BITS) / 10;
   localparam longint unsigned FLAT_LEVEL = (64'd8 << LEVEL_BITS) / 10;

   localparam int RAMP_MAX    = (1 << RAMP_W) - 1;
   localparam int SUSTAIN_MAX = (1 << SUSTAIN_W) - 1;
   localparam int TOTAL_MAX   = (1 << TOTAL_W) - 1;

   // an index past the register list, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam int PHASE_ITEMS   = 80;
   localparam int RANDOM_SETS   = 14;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = LEVEL_BITS + 8;

   typedef struct {
      logic note_start;
      logic wait_drain;   // sender holds this beat until all levels are back
   } tick_type;

   typedef struct {
      logic [LEVEL_BITS-1:0] level;
      logic [PHASE_W-1:0]    phase;
   } envelope_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   adsr_req_if req_bus ();
   adsr_rsp_if #(.LEVEL_BITS(LEVEL_BITS)) rsp_bus ();

   adsr_envelope_generator_core #(
      .COUNT_BITS(COUNT_BITS),
      .LEVEL_BITS(LEVEL_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow of the envelope registers and the note position
   logic [RAMP_W-1:0]     cfg_attack  = '0;
   logic [RAMP_W-1:0]     cfg_decay   = '0;
   logic [RAMP_W-1:0]     cfg_release = '0;
   logic [SUSTAIN_W-1:0]  cfg_sustain = '0;
   logic [TOTAL_W-1:0]    cfg_total   = '0;
   logic [COUNT_BITS-1:0] note_pos    = '0;

   tick_type     pending_ticks[$];
   envelope_type expected_levels[$];
   tick_type     next_tick;

   int  ticks_pushed    = 0;
   int  ticks_accepted  = 0;
   int  levels_checked  = 0;
   int  mismatch_count  = 0;
   int  settings_loaded = 0;
   int  idle_pct        = 9;
   int  hold_left       = 0;
   int  phase_hits[6]   = '{default: 0};
   bit  drained         = 1'b1;

   // envelope level and phase for one sample tick; advances the note position
   function automatic void envelope_for_tick(input logic restart);
      longint unsigned p, a, d, r, s, t, lvl;
      logic [PHASE_W-1:0] ph;
      envelope_type exp_beat;
      p = restart ? 64'd0 : longint'(note_pos);
      a = cfg_attack;
      d = cfg_decay;
      r = cfg_release;
      s = cfg_sustain;
      t = cfg_total;
      if (a + d + r >= t) begin
         // envelope does not fit in the note: constant level everywhere
         lvl = FLAT_LEVEL;
         ph  = PH_FLAT;
      end else if (p >= t) begin
         lvl = 0;
         ph  = PH_FINISHED;
      end else if (p < a) begin
         lvl = (PEAK_LEVEL * p) / a;
         ph  = PH_ATTACK;
      end else if (p < a + d) begin
         // sustain above peak makes the decay ramp rise
         if (s <= PEAK_LEVEL) lvl = PEAK_LEVEL - ((PEAK_LEVEL - s) * (p - a)) / d;
         else lvl = PEAK_LEVEL + ((s - PEAK_LEVEL) * (p - a)) / d;
         ph = PH_DECAY;
      end else if (p >= t - r) begin
         lvl = (s * (t - p)) / r;
         ph  = PH_RELEASE;
      end else begin
         lvl = s;
         ph  = PH_SUSTAIN;
      end
      note_pos = (p >= COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : COUNT_BITS'(p + 1);
      exp_beat.level = lvl[LEVEL_BITS-1:0];
      exp_beat.phase = ph;
      expected_levels.push_back(exp_beat);
      phase_hits[ph]++;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.note_start <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            envelope_for_tick(req_bus.note_start);
            ticks_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_ticks.size() != 0 &&
                !(pending_ticks[0].wait_drain && (req_bus.valid || !drained)) &&
                $urandom_range(99) >= idle_pct) begin
               next_tick = pending_ticks.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.note_start <= next_tick.note_start;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // sampled away from the clock edge so the driver sees a settled value
   always @(negedge clock) drained = (expected_levels.size() == 0);

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_levels.size() == 0) begin
               $error("level: no beat expected, got %0d (phase %0d)",
                      rsp_bus.level, rsp_bus.phase);
               mismatch_count++;
            end else begin
               if (rsp_bus.level !== expected_levels[0].level) begin
                  $error("level: expected %0d, actual %0d",
                         expected_levels[0].level, rsp_bus.level);
                  mismatch_count++;
               end
               if (rsp_bus.phase !== expected_levels[0].phase) begin
                  $error("phase: expected %0d, actual %0d",
                         expected_levels[0].phase, rsp_bus.phase);
                  mismatch_count++;
               end
               void'(expected_levels.pop_front());
            end
            levels_checked++;
            // long back-pressure now and then so the block fills up
            if (levels_checked % 400 == 150) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ATTACK:  cfg_attack  = data[RAMP_W-1:0];
         CSR_DECAY:   cfg_decay   = data[RAMP_W-1:0];
         CSR_RELEASE: cfg_release = data[RAMP_W-1:0];
         CSR_SUSTAIN: cfg_sustain = data[SUSTAIN_W-1:0];
         CSR_TOTAL:   cfg_total   = data[TOTAL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // junk = 1 sets bits above the ramp and sustain register widths and pokes the spare index
   task automatic load_envelope(input int a, input int d, input int r,
                                input int s, input int t, input bit junk);
      logic [3:0] hi_ramp;
      logic [8:0] hi_sus;
      hi_ramp = junk ? 4'($urandom) : 4'd0;
      hi_sus  = junk ? 9'($urandom) : 9'd0;
      write_reg(CSR_ATTACK,  {hi_ramp, RAMP_W'(a)});
      write_reg(CSR_DECAY,   {hi_ramp, RAMP_W'(d)});
      write_reg(CSR_RELEASE, {hi_ramp, RAMP_W'(r)});
      write_reg(CSR_SUSTAIN, {hi_sus, SUSTAIN_W'(s)});
      write_reg(CSR_TOTAL,   TOTAL_W'(t));
      if (junk) write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      settings_loaded++;
   endtask

   task automatic queue_tick(input logic start, input logic sync);
      tick_type beat;
      beat.note_start = start;
      beat.wait_drain = sync;
      pending_ticks.push_back(beat);
      ticks_pushed++;
   endtask

   task automatic queue_note(input int len);
      queue_tick(1'b1, 1'b0);
      repeat (len - 1) queue_tick(1'b0, 1'b0);
   endtask

   task automatic wait_drained;
      do @(negedge clock);
      while (ticks_accepted != ticks_pushed || expected_levels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int  a, d, r, s, t, t_cap, len, n_done;
      bit  synced;
      req_bus.valid      = 1'b0;
      req_bus.note_start = 1'b0;
      rsp_bus.ready      = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: zero note length falls back to the constant level
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b0, 1'b0);
      wait_drained();

      // one short note through every phase and past its end
      load_envelope(2, 3, 2, 16000, 10, 1'b0);
      queue_note(12);
      wait_drained();

      // sustain above the peak: decay climbs
      load_envelope(2, 4, 2, SUSTAIN_MAX, 10, 1'b0);
      queue_note(6);
      wait_drained();

      // all ramps of zero length: straight sustain, then finished
      load_envelope(0, 0, 0, 5000, 3, 1'b1);
      queue_note(4);
      wait_drained();

      for (int k = 0; k < RANDOM_SETS; k++) begin
         case (k)
            0: load_envelope(RAMP_MAX, RAMP_MAX, RAMP_MAX, SUSTAIN_MAX, TOTAL_MAX, 1'b1);
            1: load_envelope(0, RAMP_MAX, 0, 0, TOTAL_MAX, 1'b0);
            2: load_envelope(0, 0, RAMP_MAX, SUSTAIN_MAX, RAMP_MAX + 6, 1'b1);
            // ramps exactly fill the note: constant level
            3: load_envelope(3, 4, 5, $urandom_range(SUSTAIN_MAX), 12, 1'b0);
            default: begin
               a = $urandom_range(10);
               d = $urandom_range(10);
               r = $urandom_range(10);
               case ($urandom_range(3))
                  0: s = 0;
                  1: s = SUSTAIN_MAX;
                  2: s = int'(PEAK_LEVEL);
                  default: s = $urandom_range(SUSTAIN_MAX);
               endcase
               t = $urandom_range(a + d + r + 25);
               load_envelope(a, d, r, s, t, 1'($urandom));
            end
         endcase
         // one set runs with no idling on either side
         idle_pct = (k == 5) ? 0 : 9;
         t_cap  = (cfg_total > 40) ? 40 : int'(cfg_total);
         n_done = 0;
         synced = 1'b0;
         while (n_done < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               // stray ticks that may start or continue anywhere
               len = $urandom_range(3, 1);
               repeat (len) queue_tick(1'($urandom), 1'b0);
            end else begin
               len = $urandom_range(t_cap + 4, 1);
               queue_tick(1'b1, (n_done >= 40 && !synced) || $urandom_range(29) == 0);
               if (n_done >= 40) synced = 1'b1;
               repeat (len - 1) queue_tick(1'b0, 1'b0);
            end
            n_done += len;
         end
         wait_drained();
      end

      $display("Ran %0d sample ticks over %0d envelope settings, %0d levels checked.",
               ticks_accepted, settings_loaded, levels_checked);
      $display("Phases: attack %0d, decay %0d, sustain %0d, release %0d, finished %0d, flat %0d.",
               phase_hits[PH_ATTACK], phase_hits[PH_DECAY], phase_hits[PH_SUSTAIN],
               phase_hits[PH_RELEASE], phase_hits[PH_FINISHED], phase_hits[PH_FLAT]);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Timed out with %0d ticks accepted and %0d levels outstanding.",
               ticks_accepted, expected_levels.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== adsr_envelope_generator_core.f =====
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_if.sv
hw/rtl/adsr_mul_div.sv
hw/rtl/adsr_envelope_generator_core.sv
sim/adsr_envelope_generator_core_tb.sv
